// ===== rtl/itoaf_pkg.sv =====
// Shared constants, types and the digit character function of the integer
// to ASCII formatter. No dependencies.
package itoaf_pkg;

    localparam int VALUE_BITS    = 64;
    localparam int SCRATCH_CHARS = 64;
    localparam int MAX_DIGITS    = 64;
    localparam int MAG_W         = 64;
    localparam int DIV_BITS      = 8;
    localparam int DIV_STEPS     = MAG_W / DIV_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
    localparam int CNT_W         = 7;
    localparam int LEN_W         = 8;

    localparam logic [MAG_W-1:0] VALUE_MASK = {MAG_W{1'b1}} >> (MAG_W - VALUE_BITS);

    localparam int FL_ZEROPAD = 0;
    localparam int FL_LEFT    = 1;
    localparam int FL_PLUS    = 2;
    localparam int FL_SPACE   = 3;
    localparam int FL_PREFIX  = 4;
    localparam int FL_SIGNED  = 5;
    localparam int FL_UPPER   = 6;

    localparam logic [4:0] RADIX_MIN  = 5'd2;
    localparam logic [4:0] RADIX_BIN  = 5'd2;
    localparam logic [4:0] RADIX_QUAT = 5'd4;
    localparam logic [4:0] RADIX_OCT  = 5'd8;
    localparam logic [4:0] RADIX_HEX  = 5'd16;
    localparam logic [4:0] RADIX_MAX  = 5'd16;

    localparam logic [6:0] LIMIT_64 = 7'd64;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_last;
        logic plan;
        logic emit;
    } itoaf_cmd_t;

    typedef struct packed {
        logic pow2;
        logic more;
        logic emit_ready;
        logic emit_last;
    } itoaf_sts_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            return CH_ZERO + {4'b0, d};
        end
        base = upper ? CH_UPPER_A : CH_LOWER_A;
        return base + {4'b0, d} - 8'd10;
    endfunction

endpackage

// ===== rtl/itoaf_ctrl.sv =====
// Sequencer of the integer to ASCII formatter: accepts requests and steps
// the datapath through digit generation, planning and emission. Uses itoaf_pkg.
module itoaf_ctrl
    import itoaf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  itoaf_sts_t sts,
    output itoaf_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_PLAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                cnt_next = '0;
                if (s_valid) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                cmd.div_last = sts.pow2 || (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
                if (cmd.div_last) begin
                    cnt_next = '0;
                    if (!sts.more) begin
                        state_next = S_PLAN;
                    end
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_PLAN: begin
                cmd.plan   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit = sts.emit_ready;
                if (sts.emit_ready && sts.emit_last) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/itoaf_dp.sv =====
// Datapath of the integer to ASCII formatter: request registers, remainder
// unit, digit stack, segment counters and output register. Uses itoaf_pkg.
module itoaf_dp
    import itoaf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  itoaf_cmd_t       cmd,
    output itoaf_sts_t       sts,
    input  logic [MAG_W-1:0] s_magnitude,
    input  logic             s_is_negative,
    input  logic [6:0]       s_format_flags,
    input  logic [6:0]       s_field_width,
    input  logic [6:0]       s_min_digits,
    input  logic [4:0]       s_radix,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_last_char
);

    localparam logic [2:0] SEG_LEAD  = 3'd0;
    localparam logic [2:0] SEG_SIGN  = 3'd1;
    localparam logic [2:0] SEG_PRE   = 3'd2;
    localparam logic [2:0] SEG_ZERO  = 3'd3;
    localparam logic [2:0] SEG_DIGIT = 3'd4;
    localparam logic [2:0] SEG_TRAIL = 3'd5;

    logic [MAG_W-1:0] val_reg;
    logic [3:0]       rem_reg;
    logic [4:0]       rad_reg;
    logic [6:0]       flags_reg;
    logic [6:0]       fw_reg;
    logic [6:0]       prec_reg;
    logic             neg_reg;
    logic [3:0]       stk_reg [MAX_DIGITS];
    logic [CNT_W-1:0] nd_reg;

    logic [CNT_W-1:0] lead_reg, zero_reg, trail_reg, skip_reg, left_reg;
    logic             sgn_reg;
    logic [7:0]       sign_ch_reg;
    logic [1:0]       pre_reg;
    logic [7:0]       letter_reg;

    logic             m_valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;

    logic [4:0]       rad_in;
    logic [6:0]       fw_in, prec_in;

    logic [DIV_BITS-1:0] div_q;
    logic [3:0]          div_rem;
    logic [MAG_W-1:0]    div_quot;
    logic [3:0]          p2_digit;
    logic [MAG_W-1:0]    p2_quot;
    logic [3:0]          step_digit;
    logic [MAG_W-1:0]    step_quot;
    logic [6:0]          prec_after;
    logic                push, pop;
    logic                pow2_hit, step_more, emit_ready, emit_last;

    logic             pl_sgn;
    logic [7:0]       pl_sign_ch;
    logic [1:0]       pl_np;
    logic [7:0]       pl_letter;
    logic [LEN_W-1:0] pl_fw, pl_core, pl_fill, pl_len, pl_trail, pl_total;
    logic             pl_left, pl_zp, pl_over;

    logic [2:0]       seg;
    logic [7:0]       emit_ch;
    logic             emit_out;

    always_comb begin
        rad_in = s_radix;
        if (s_radix > RADIX_MAX) begin
            rad_in = RADIX_MAX;
        end else if (s_radix < RADIX_MIN) begin
            rad_in = RADIX_MIN;
        end
        fw_in   = (s_field_width > LIMIT_64) ? LIMIT_64 : s_field_width;
        prec_in = (s_min_digits > LIMIT_64) ? LIMIT_64 : s_min_digits;
    end

    // long division, DIV_BITS dividend bits per step
    always_comb begin
        logic [4:0] t;
        logic [3:0] r;
        r     = rem_reg;
        div_q = '0;
        for (int b = DIV_BITS - 1; b >= 0; b--) begin
            t = {r, val_reg[MAG_W - DIV_BITS + b]};
            if (t >= rad_reg) begin
                div_q[b] = 1'b1;
                t        = t - rad_reg;
            end
            r = t[3:0];
        end
        div_rem  = r;
        div_quot = {val_reg[MAG_W-DIV_BITS-1:0], div_q};
    end

    always_comb begin
        pow2_hit = 1'b1;
        p2_digit = '0;
        p2_quot  = val_reg;
        case (rad_reg)
            RADIX_BIN: begin
                p2_digit = {3'b0, val_reg[0]};
                p2_quot  = val_reg >> 1;
            end
            RADIX_QUAT: begin
                p2_digit = {2'b0, val_reg[1:0]};
                p2_quot  = val_reg >> 2;
            end
            RADIX_OCT: begin
                p2_digit = {1'b0, val_reg[2:0]};
                p2_quot  = val_reg >> 3;
            end
            RADIX_HEX: begin
                p2_digit = val_reg[3:0];
                p2_quot  = val_reg >> 4;
            end
            default: begin
                pow2_hit = 1'b0;
            end
        endcase
        step_digit = pow2_hit ? p2_digit : div_rem;
        step_quot  = pow2_hit ? p2_quot : div_quot;
        prec_after = (prec_reg != '0) ? prec_reg - 1'b1 : prec_reg;
        step_more  = ((step_quot != '0) || (prec_after != '0))
                     && (nd_reg != CNT_W'(MAX_DIGITS - 1));
    end

    always_comb begin
        pl_sgn     = 1'b1;
        pl_sign_ch = CH_SPACE;
        if (neg_reg && flags_reg[FL_SIGNED]) begin
            pl_sign_ch = CH_MINUS;
        end else if (flags_reg[FL_SPACE]) begin
            pl_sign_ch = CH_SPACE;
        end else if (flags_reg[FL_PLUS]) begin
            pl_sign_ch = CH_PLUS;
        end else begin
            pl_sgn = 1'b0;
        end
        pl_np     = 2'd0;
        pl_letter = CH_ZERO;
        if (flags_reg[FL_PREFIX]) begin
            if (rad_reg == RADIX_BIN) begin
                pl_np     = 2'd2;
                pl_letter = CH_LOWER_B;
            end else if (rad_reg == RADIX_HEX) begin
                pl_np     = 2'd2;
                pl_letter = CH_LOWER_X;
            end else if (rad_reg == RADIX_OCT && stk_reg[0] != 4'd0) begin
                pl_np = 2'd1;
            end
        end
        pl_left  = flags_reg[FL_LEFT];
        pl_zp    = flags_reg[FL_ZEROPAD] && !pl_left;
        pl_fw    = LEN_W'(fw_reg);
        pl_core  = LEN_W'(nd_reg) + LEN_W'(pl_np) + LEN_W'(pl_sgn);
        pl_fill  = (pl_fw > pl_core) ? pl_fw - pl_core : '0;
        pl_len   = pl_left ? pl_core : pl_core + pl_fill;
        pl_trail = pl_left ? pl_fill : '0;
        pl_over  = pl_len > LEN_W'(SCRATCH_CHARS);
        pl_total = (pl_over ? LEN_W'(SCRATCH_CHARS) : pl_len) + pl_trail;
    end

    always_comb begin
        if (lead_reg != '0) begin
            seg     = SEG_LEAD;
            emit_ch = CH_SPACE;
        end else if (sgn_reg) begin
            seg     = SEG_SIGN;
            emit_ch = sign_ch_reg;
        end else if (pre_reg != 2'd0) begin
            seg     = SEG_PRE;
            emit_ch = (pre_reg == 2'd2) ? CH_ZERO : letter_reg;
        end else if (zero_reg != '0) begin
            seg     = SEG_ZERO;
            emit_ch = CH_ZERO;
        end else if (nd_reg != '0) begin
            seg     = SEG_DIGIT;
            emit_ch = digit_char(stk_reg[0], flags_reg[FL_UPPER]);
        end else begin
            seg     = SEG_TRAIL;
            emit_ch = CH_SPACE;
        end
        emit_ready = (skip_reg != '0) || !m_valid_reg || m_ready;
        emit_last  = (skip_reg == '0) && (left_reg == CNT_W'(1));
    end

    assign emit_out = cmd.emit && (skip_reg == '0);

    assign sts = '{pow2: pow2_hit, more: step_more, emit_ready: emit_ready,
                   emit_last: emit_last};

    assign push = cmd.div_step && cmd.div_last;
    assign pop  = cmd.emit && (seg == SEG_DIGIT);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            val_reg   <= s_magnitude & VALUE_MASK;
            rem_reg   <= '0;
            rad_reg   <= rad_in;
            flags_reg <= s_format_flags;
            fw_reg    <= fw_in;
            prec_reg  <= prec_in;
            neg_reg   <= s_is_negative;
        end else if (cmd.div_step) begin
            val_reg <= step_quot;
            if (cmd.div_last) begin
                rem_reg  <= '0;
                prec_reg <= prec_after;
            end else begin
                rem_reg <= div_rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            stk_reg[0] <= step_digit;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_DIGITS - 1; i++) begin
                stk_reg[i] <= stk_reg[i+1];
            end
            stk_reg[MAX_DIGITS-1] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            nd_reg <= '0;
        end else if (push) begin
            nd_reg <= nd_reg + 1'b1;
        end else if (pop) begin
            nd_reg <= nd_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.plan) begin
            lead_reg    <= (!pl_left && !pl_zp) ? pl_fill[CNT_W-1:0] : '0;
            zero_reg    <= pl_zp ? pl_fill[CNT_W-1:0] : '0;
            trail_reg   <= pl_trail[CNT_W-1:0];
            skip_reg    <= pl_over ? CNT_W'(pl_len - LEN_W'(SCRATCH_CHARS)) : '0;
            left_reg    <= pl_total[CNT_W-1:0];
            sgn_reg     <= pl_sgn;
            sign_ch_reg <= pl_sign_ch;
            pre_reg     <= pl_np;
            letter_reg  <= pl_letter;
        end else if (cmd.emit) begin
            case (seg)
                SEG_LEAD:  lead_reg  <= lead_reg - 1'b1;
                SEG_SIGN:  sgn_reg   <= 1'b0;
                SEG_PRE:   pre_reg   <= pre_reg - 1'b1;
                SEG_ZERO:  zero_reg  <= zero_reg - 1'b1;
                SEG_TRAIL: trail_reg <= trail_reg - 1'b1;
                default: begin
                end
            endcase
            if (skip_reg != '0) begin
                skip_reg <= skip_reg - 1'b1;
            end else begin
                left_reg <= left_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_out) begin
            char_reg <= emit_ch;
            last_reg <= emit_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_char  = char_reg;
    assign m_last_char = last_reg;

endmodule

// ===== rtl/integer_to_ascii_formatter_unit.sv =====
// Top level of the integer to ASCII formatter: joins the sequencer and the
// datapath. Uses itoaf_pkg, itoaf_ctrl and itoaf_dp.
//
// A request on the s_ channel carries a magnitude, a negative mark, flags,
// field width, minimum digit count and radix. The m_ channel returns the
// formatted text one ASCII character per transfer, most significant first,
// with m_last_char set on the final character; every request yields 1 to 64.
// s_ready is high only while the sequencer is idle: one request at a time.
// A request is loaded, then one digit is generated per cycle for radix 2, 4,
// 8 or 16; for other radices each digit takes a full pass of the remainder
// unit over the value, 8 dividend bits a cycle. The padding is planned and
// the characters go out one per cycle while the receiver does not stall; up
// to 3 leading characters that are dropped still pass through the sequencer.
// The first character follows the planning state into the output register.
// A stalled receiver holds the output register and the character sequencer;
// the final character waits in the output register while the next request
// is taken. Reset empties the output register and returns to idle.
module integer_to_ascii_formatter_unit
    import itoaf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [MAG_W-1:0] s_magnitude,
    input  logic             s_is_negative,
    input  logic [6:0]       s_format_flags,
    input  logic [6:0]       s_field_width,
    input  logic [6:0]       s_min_digits,
    input  logic [4:0]       s_radix,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_last_char
);

    itoaf_cmd_t cmd;
    itoaf_sts_t sts;

    itoaf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    itoaf_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .s_magnitude    (s_magnitude),
        .s_is_negative  (s_is_negative),
        .s_format_flags (s_format_flags),
        .s_field_width  (s_field_width),
        .s_min_digits   (s_min_digits),
        .s_radix        (s_radix),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_last_char    (m_last_char)
    );

endmodule

// ===== bench/integer_to_ascii_formatter_unit_tb.sv =====
// Self-checking bench for integer_to_ascii_formatter_unit: directed and random requests,
// each predicted into the expected character string and checked as the text comes back.
// Depends on itoaf_pkg and the integer_to_ascii_formatter_unit RTL.
module integer_to_ascii_formatter_unit_tb;
    import itoaf_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 20;

    localparam logic [6:0] FLAG_ZEROPAD = 7'(1 << FL_ZEROPAD);
    localparam logic [6:0] FLAG_LEFT    = 7'(1 << FL_LEFT);
    localparam logic [6:0] FLAG_PLUS    = 7'(1 << FL_PLUS);
    localparam logic [6:0] FLAG_SPACE   = 7'(1 << FL_SPACE);
    localparam logic [6:0] FLAG_PREFIX  = 7'(1 << FL_PREFIX);
    localparam logic [6:0] FLAG_SIGNED  = 7'(1 << FL_SIGNED);
    localparam logic [6:0] FLAG_UPPER   = 7'(1 << FL_UPPER);

    localparam logic [4:0]  RADIX_DEC = 5'd10;
    localparam logic [63:0] MAG_ALL   = {MAG_W{1'b1}};

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    logic             aclk           = 1'b0;
    logic             aresetn        = 1'b0;
    logic             s_valid        = 1'b0;
    logic             s_ready;
    logic [MAG_W-1:0] s_magnitude    = '0;
    logic             s_is_negative  = 1'b0;
    logic [6:0]       s_format_flags = '0;
    logic [6:0]       s_field_width  = '0;
    logic [6:0]       s_min_digits   = '0;
    logic [4:0]       s_radix        = RADIX_DEC;
    logic             m_valid;
    logic             m_ready        = 1'b0;
    logic [7:0]       m_out_char;
    logic             m_last_char;

    text_char_t expected_text[$];
    int         errors       = 0;
    int         quiet_cycles = 0;
    int         rx_hold      = 0;
    logic       idle_on      = 1'b1;

    integer_to_ascii_formatter_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_magnitude   (s_magnitude),
        .s_is_negative (s_is_negative),
        .s_format_flags(s_format_flags),
        .s_field_width (s_field_width),
        .s_min_digits  (s_min_digits),
        .s_radix       (s_radix),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_char   (m_last_char)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic void format_number(input logic [63:0] mag, input logic neg,
                                          input logic [6:0] flags, input logic [6:0] fw_in,
                                          input logic [6:0] md_in, input logic [4:0] radix);
        logic [63:0] v;
        logic [63:0] base;
        logic [3:0]  d;
        logic [7:0]  dig [64];
        logic [7:0]  line [72];
        logic [7:0]  text [64];
        logic [7:0]  sgn;
        logic [7:0]  pre1;
        int          nd, np, len, start, k, fw, prec, core;
        logic        left_j, zpad, upper;
        text_char_t  item;
        v      = mag & VALUE_MASK;
        base   = (radix > RADIX_MAX) ? 64'(RADIX_MAX) :
                 (radix < RADIX_MIN) ? 64'(RADIX_MIN) : 64'(radix);
        fw     = (fw_in > LIMIT_64) ? int'(LIMIT_64) : int'(fw_in);
        prec   = (md_in > LIMIT_64) ? int'(LIMIT_64) : int'(md_in);
        upper  = flags[FL_UPPER];
        left_j = flags[FL_LEFT];
        zpad   = flags[FL_ZEROPAD] && !left_j;
        pre1   = CH_ZERO;
        nd     = 0;
        do begin
            d = 4'(v % base);
            dig[nd] = (d < 4'd10) ? CH_ZERO + 8'(d)
                                  : (upper ? CH_UPPER_A : CH_LOWER_A) + 8'(d) - 8'd10;
            nd++;
            v = v / base;
            if (prec != 0) prec--;
        end while ((v != 0 || prec != 0) && nd < MAX_DIGITS);

        sgn = 8'h00;
        if (neg && flags[FL_SIGNED]) sgn = CH_MINUS;
        else if (flags[FL_SPACE]) sgn = CH_SPACE;
        else if (flags[FL_PLUS]) sgn = CH_PLUS;

        np = 0;
        if (flags[FL_PREFIX]) begin
            if (base == RADIX_BIN) begin
                pre1 = CH_LOWER_B;
                np   = 2;
            end else if (base == RADIX_HEX) begin
                pre1 = CH_LOWER_X;
                np   = 2;
            end else if (base == RADIX_OCT && dig[nd-1] != CH_ZERO) begin
                np = 1;
            end
        end

        core = nd + np + ((sgn != 8'h00) ? 1 : 0);
        len  = 0;
        if (!left_j && !zpad)
            while (len + core < fw) line[len++] = CH_SPACE;
        if (sgn != 8'h00) line[len++] = sgn;
        if (np > 0) line[len++] = CH_ZERO;
        if (np > 1) line[len++] = pre1;
        if (zpad)
            while (len + nd < fw) line[len++] = CH_ZERO;
        for (int i = nd - 1; i >= 0; i--) line[len++] = dig[i];

        // drop leading characters that do not fit the scratch store
        start = (len > SCRATCH_CHARS) ? len - SCRATCH_CHARS : 0;
        k = 0;
        for (int i = start; i < len && k < MAX_DIGITS; i++) text[k++] = line[i];
        if (left_j) begin
            while (len < fw && k < MAX_DIGITS) begin
                text[k++] = CH_SPACE;
                len++;
            end
        end
        for (int i = 0; i < k; i++) begin
            item.ch   = text[i];
            item.last = (i == k - 1);
            expected_text.push_back(item);
        end
    endfunction

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_text.size() == 0) begin
                    $error("out_char: expected none, actual %02h", m_out_char);
                    errors++;
                end else begin
                    want = expected_text.pop_front();
                    if (m_out_char !== want.ch) begin
                        $error("out_char: expected %02h, actual %02h", want.ch, m_out_char);
                        errors++;
                    end
                    if (m_last_char !== want.last) begin
                        $error("last_char: expected %0b, actual %0b", want.last, m_last_char);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                format_number(s_magnitude, s_is_negative, s_format_flags, s_field_width,
                              s_min_digits, s_radix);
        end
    end

    always @(posedge aclk) begin
        int draw;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= 0;
        end else if (m_valid && m_ready) begin
            draw = idle_on ? $urandom_range(0, 6) : 0;
            rx_hold <= draw;
            m_ready <= (draw == 0);
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_ready <= (rx_hold == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("integer_to_ascii_formatter_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [63:0] mag, input logic neg, input logic [6:0] flags,
                                input logic [6:0] fw, input logic [6:0] md,
                                input logic [4:0] radix);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_magnitude    <= mag;
        s_is_negative  <= neg;
        s_format_flags <= flags;
        s_field_width  <= fw;
        s_min_digits   <= md;
        s_radix        <= radix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic test_extremes();
        send_request(64'd0, 1'b0, 7'd0, 7'd0, 7'd0, RADIX_DEC);
        send_request(MAG_ALL, 1'b0, 7'd0, 7'd0, 7'd0, RADIX_BIN);
        send_request(MAG_ALL, 1'b1, FLAG_UPPER | FLAG_PREFIX, 7'd0, 7'd0, RADIX_HEX);
        send_request(64'd5, 1'b0, 7'd0, 7'd0, 7'd0, 5'd0);
        send_request(64'd7, 1'b0, FLAG_PREFIX, 7'd0, 7'd0, 5'd1);
        send_request(MAG_ALL, 1'b1, FLAG_SIGNED | FLAG_UPPER, 7'd0, 7'd0, 5'd31);
    endtask

    task automatic test_signs();
        send_request(64'd42, 1'b1, FLAG_SIGNED | FLAG_SPACE | FLAG_PLUS, 7'd0, 7'd0, RADIX_DEC);
        send_request(64'd42, 1'b1, FLAG_SPACE | FLAG_PLUS, 7'd0, 7'd0, RADIX_DEC);
        send_request(64'd42, 1'b0, FLAG_PLUS, 7'd0, 7'd0, RADIX_DEC);
        send_request(64'd42, 1'b1, 7'd0, 7'd0, 7'd0, RADIX_DEC);
    endtask

    task automatic test_prefixes();
        send_request(64'd255, 1'b0, FLAG_PREFIX, 7'd0, 7'd0, RADIX_HEX);
        send_request(64'hABC, 1'b0, FLAG_PREFIX | FLAG_UPPER, 7'd0, 7'd0, RADIX_HEX);
        send_request(64'd5, 1'b0, FLAG_PREFIX, 7'd0, 7'd0, RADIX_BIN);
        send_request(64'd0, 1'b0, FLAG_PREFIX, 7'd0, 7'd0, RADIX_OCT);
        send_request(64'd8, 1'b0, FLAG_PREFIX, 7'd0, 7'd0, RADIX_OCT);
        send_request(64'd8, 1'b0, FLAG_PREFIX, 7'd0, 7'd4, RADIX_OCT);
        send_request(64'd99, 1'b0, FLAG_PREFIX, 7'd0, 7'd0, RADIX_DEC);
    endtask

    task automatic test_padding();
        send_request(64'd1234, 1'b1, FLAG_SIGNED, 7'd12, 7'd0, RADIX_DEC);
        send_request(64'h1234, 1'b0, FLAG_PLUS | FLAG_ZEROPAD | FLAG_PREFIX, 7'd12, 7'd0,
                     RADIX_HEX);
        send_request(64'd77, 1'b0, FLAG_LEFT, 7'd12, 7'd0, RADIX_DEC);
        send_request(64'd77, 1'b0, FLAG_LEFT | FLAG_ZEROPAD | FLAG_SPACE, 7'd12, 7'd3,
                     RADIX_DEC);
        send_request(64'd3, 1'b0, 7'd0, 7'd127, 7'd0, RADIX_DEC);
        send_request(64'd3, 1'b0, FLAG_ZEROPAD, 7'd5, 7'd127, RADIX_DEC);
    endtask

    task automatic test_long_text();
        send_request(MAG_ALL, 1'b1, FLAG_SIGNED | FLAG_PREFIX, 7'd0, 7'd0, RADIX_BIN);
        send_request(64'd1, 1'b0, FLAG_PREFIX | FLAG_PLUS, 7'd0, 7'd64, RADIX_HEX);
        send_request(MAG_ALL, 1'b0, FLAG_LEFT, 7'd64, 7'd0, RADIX_BIN);
        send_request(64'd1, 1'b0, FLAG_LEFT | FLAG_SPACE, 7'd100, 7'd64, RADIX_DEC);
    endtask

    task automatic test_random(input int count);
        logic [63:0] mag;
        logic [6:0]  fw, md;
        logic [4:0]  radix;
        int          pick;
        for (int n = 0; n < count; n++) begin
            // hold a stretch without idling at the start
            idle_on <= (n >= count / 4);
            mag = {$urandom(), $urandom()};
            if ($urandom_range(0, 3) != 0) mag = mag >> $urandom_range(0, 63);
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1: begin
                    radix = RADIX_DEC;
                end
                2: begin
                    radix = RADIX_BIN;
                end
                3: begin
                    radix = RADIX_OCT;
                end
                4, 5: begin
                    radix = RADIX_HEX;
                end
                6, 7, 8: begin
                    radix = 5'($urandom_range(2, 16));
                end
                default: begin
                    radix = 5'($urandom_range(0, 31));
                end
            endcase
            fw = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 24));
            md = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 24));
            send_request(mag, 1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), fw, md,
                         radix);
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_extremes();
        test_signs();
        test_prefixes();
        test_padding();
        test_long_text();
        test_random(200);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_text.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("integer_to_ascii_formatter_unit: match");
        end else begin
            $display("integer_to_ascii_formatter_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/itoaf_pkg.sv
rtl/itoaf_ctrl.sv
rtl/itoaf_dp.sv
rtl/integer_to_ascii_formatter_unit.sv
bench/integer_to_ascii_formatter_unit_tb.sv
